[design/twss_pkg.sv]
// Shared types, sizes and codes for the time-window sample statistics block.
// Depends on nothing; the design files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package twss_pkg;

    localparam int DEPTH    = 64;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int AGE_W    = 31;
    localparam int THR_W    = TIME_W + 1;
    localparam int ENTRY_W  = TIME_W + SAMPLE_W;
    localparam int SUM_W    = SAMPLE_W + IDX_W + 1;
    localparam int MAG_W    = SUM_W - 1;
    localparam int STEP_W   = $clog2(MAG_W + 1);

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic signed [TIME_W-1:0]   timestamp;
        logic [AGE_W-1:0]           window_age;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] window_average;
        logic signed [SAMPLE_W-1:0] window_maximum;
        logic signed [SAMPLE_W-1:0] window_minimum;
        logic [CNT_W-1:0]           window_count;
        logic [CNT_W-1:0]           stored_count;
    } rsp_t;

    // Ring position k entries after the oldest one.
    function automatic logic [IDX_W-1:0] ring_at(input logic [IDX_W-1:0] oldest,
                                                 input logic [CNT_W-1:0] k);
        logic [CNT_W:0] p;
        p = (CNT_W+1)'(oldest) + (CNT_W+1)'(k);
        if (p >= (CNT_W+1)'(DEPTH))
        begin
            p = p - (CNT_W+1)'(DEPTH);
        end
        return p[IDX_W-1:0];
    endfunction

endpackage

[design/time_window_sample_stats.sv]
// Top level of the time-window sample statistics block: control sequencer,
// ring bookkeeping and result register. Uses twss_pkg, twss_ram, twss_div.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid / req_stall / req): one beat per request.
//   req_type add stores a sample with its timestamp, dropping the oldest
//   one when all 64 entries are taken; query scans the held samples from
//   oldest to newest and reports average, maximum, minimum and count of the
//   suffix starting at the first timestamp >= timestamp - window_age; clear
//   empties the ring. Every request yields exactly one response beat on
//   rsp_valid / rsp_stall / rsp.
//   Flow: add, clear and the unused code pass through the execute and done
//   states; a query also scans, with one memory read per held entry through
//   the single read port, and then runs the one-bit-per-cycle divider for
//   the average (a query hitting no sample skips the divider). One request
//   is in work at a time.
//   The response sits in an output register, so a new request is taken
//   while the previous response still waits on a stalled receiver; a
//   finished result waits in its final state until that register frees.
//   Reset empties the ring at once (fill count and oldest position go to
//   zero); the memory itself is not cleared, since only held entries are read.

module time_window_sample_stats (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  twss_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output twss_pkg::rsp_t    rsp
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                                 state_reg, state_next;
    twss_pkg::req_t                         req_reg, req_next;
    twss_pkg::rsp_t                         res_reg, res_next;
    twss_pkg::rsp_t                         rsp_reg, rsp_next;
    logic                                   rsp_valid_reg, rsp_valid_next;

    logic [twss_pkg::CNT_W-1:0]             fill_reg, fill_next;
    logic [twss_pkg::IDX_W-1:0]             oldest_reg, oldest_next;
    logic [twss_pkg::CNT_W-1:0]             scan_k_reg, scan_k_next;
    logic                                   pend_reg, pend_next;
    logic                                   found_reg, found_next;
    logic signed [twss_pkg::THR_W-1:0]      thr_reg, thr_next;
    logic signed [twss_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic signed [twss_pkg::SAMPLE_W-1:0]   hi_reg, hi_next;
    logic signed [twss_pkg::SAMPLE_W-1:0]   lo_reg, lo_next;
    logic [twss_pkg::CNT_W-1:0]             cnt_reg, cnt_next;

    logic                                   ram_we;
    logic [twss_pkg::IDX_W-1:0]             ram_waddr;
    logic [twss_pkg::ENTRY_W-1:0]           ram_wdata;
    logic [twss_pkg::IDX_W-1:0]             ram_raddr;
    logic [twss_pkg::ENTRY_W-1:0]           ram_rdata;

    logic                                   div_start;
    logic                                   div_done;
    logic signed [twss_pkg::SAMPLE_W-1:0]   div_quotient;

    logic [twss_pkg::TIME_W-1:0]            entry_time;
    logic signed [twss_pkg::SAMPLE_W-1:0]   entry_sample;
    logic                                   hit;
    logic                                   rsp_load;

    // Entries hold {timestamp, sample}.
    twss_ram #(
        .WIDTH (twss_pkg::ENTRY_W),
        .DEPTH (twss_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    twss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign entry_time   = ram_rdata[twss_pkg::ENTRY_W-1 -: twss_pkg::TIME_W];
    assign entry_sample = $signed(ram_rdata[twss_pkg::SAMPLE_W-1:0]);
    // once one entry qualifies, every newer entry belongs to the window
    assign hit = found_reg || ($signed({entry_time[twss_pkg::TIME_W-1], entry_time}) >= thr_reg);
    assign rsp_load = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        scan_k_next    = scan_k_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        thr_next       = thr_reg;
        sum_next       = sum_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        cnt_next       = cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = {req_reg.timestamp, req_reg.sample_value};
        ram_raddr      = '0;
        div_start      = 1'b0;

        // drop the response beat once the receiver takes it
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_DONE;
                case (req_reg.req_type)
                    twss_pkg::REQ_ADD:
                    begin
                        ram_we = 1'b1;
                        if (fill_reg == twss_pkg::CNT_W'(twss_pkg::DEPTH))
                        begin
                            // full ring: overwrite the oldest, advance it
                            ram_waddr   = oldest_reg;
                            oldest_next = twss_pkg::ring_at(oldest_reg, twss_pkg::CNT_W'(1));
                        end
                        else
                        begin
                            ram_waddr = twss_pkg::ring_at(oldest_reg, fill_reg);
                            fill_next = fill_reg + 1'b1;
                        end
                        res_next.stored_count = fill_next;
                    end
                    twss_pkg::REQ_QUERY:
                    begin
                        thr_next = $signed({req_reg.timestamp[twss_pkg::TIME_W-1],
                                            req_reg.timestamp})
                                 - $signed({2'b00, req_reg.window_age});
                        scan_k_next = '0;
                        found_next  = 1'b0;
                        sum_next    = '0;
                        hi_next     = twss_pkg::SAMPLE_MIN;
                        lo_next     = twss_pkg::SAMPLE_MAX;
                        cnt_next    = '0;
                        state_next  = S_SCAN;
                    end
                    twss_pkg::REQ_CLEAR:
                    begin
                        fill_next             = '0;
                        oldest_next           = '0;
                        res_next.stored_count = '0;
                    end
                    default:
                    begin
                        res_next.stored_count = fill_reg;
                    end
                endcase
            end

            S_SCAN:
            begin
                // issue the next read; its data arrives in the next cycle
                if (scan_k_reg != fill_reg)
                begin
                    ram_raddr   = twss_pkg::ring_at(oldest_reg, scan_k_reg);
                    pend_next   = 1'b1;
                    scan_k_next = scan_k_reg + 1'b1;
                end

                if (pend_reg && hit)
                begin
                    found_next = 1'b1;
                    sum_next   = sum_reg + twss_pkg::SUM_W'(entry_sample);
                    cnt_next   = cnt_reg + 1'b1;
                    if (entry_sample > hi_reg)
                    begin
                        hi_next = entry_sample;
                    end
                    if (entry_sample < lo_reg)
                    begin
                        lo_next = entry_sample;
                    end
                end

                if (scan_k_reg == fill_reg && !pend_reg)
                begin
                    res_next.window_average = '0;
                    res_next.window_maximum = hi_reg;
                    res_next.window_minimum = lo_reg;
                    res_next.window_count   = cnt_reg;
                    res_next.stored_count   = fill_reg;
                    if (cnt_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_next.window_average = div_quotient;
                    state_next              = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold the result until the output register frees
                if (rsp_load)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            scan_k_reg    <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            sum_reg       <= '0;
            hi_reg        <= twss_pkg::SAMPLE_MIN;
            lo_reg        <= twss_pkg::SAMPLE_MAX;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            scan_k_reg    <= scan_k_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            sum_reg       <= sum_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        thr_reg <= thr_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

endmodule

[design/twss_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module twss_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/twss_div.sv]
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Depends on twss_pkg for widths.
`timescale 1ns / 1ps

module twss_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [twss_pkg::SUM_W-1:0]      dividend,
    input  logic [twss_pkg::CNT_W-1:0]             divisor,
    output logic                                   done,
    output logic signed [twss_pkg::SAMPLE_W-1:0]   quotient
);

    logic                               busy_reg, busy_next;
    logic [twss_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [twss_pkg::MAG_W-1:0]         quo_reg, quo_next;
    logic [twss_pkg::CNT_W-1:0]         rem_reg, rem_next;
    logic [twss_pkg::CNT_W-1:0]         dsr_reg, dsr_next;
    logic                               neg_reg, neg_next;
    logic [twss_pkg::CNT_W:0]           trial;
    logic [twss_pkg::SUM_W-1:0]         mag;
    logic [twss_pkg::SAMPLE_W-1:0]      qmag;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        done      = 1'b0;
        trial     = {rem_reg, quo_reg[twss_pkg::MAG_W-1]};
        mag       = dividend[twss_pkg::SUM_W-1] ? (-dividend) : dividend;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = twss_pkg::STEP_W'(twss_pkg::MAG_W);
            quo_next  = mag[twss_pkg::MAG_W-1:0];
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = dividend[twss_pkg::SUM_W-1];
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                done      = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                // shift in the next dividend bit, subtract when it fits
                if (trial >= {1'b0, dsr_reg})
                begin
                    rem_next = twss_pkg::CNT_W'(trial - {1'b0, dsr_reg});
                    quo_next = {quo_reg[twss_pkg::MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[twss_pkg::CNT_W-1:0];
                    quo_next = {quo_reg[twss_pkg::MAG_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
            end
        end
    end

    assign qmag     = quo_reg[twss_pkg::SAMPLE_W-1:0];
    assign quotient = neg_reg ? $signed(-qmag) : $signed(qmag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

endmodule

[dv/time_window_sample_stats_tb.sv]
// Self-checking testbench for time_window_sample_stats: drives request beats,
// predicts each response from a local ring model and checks it field by field.
// Depends on twss_pkg and the time_window_sample_stats RTL.
`timescale 1ns / 1ps

module time_window_sample_stats_tb;

    import twss_pkg::*;

    // The package names three request codes; the fourth is legal on the wire
    // and must leave the ring untouched.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic [AGE_W-1:0]         AGE_MAX  = {AGE_W{1'b1}};

    // Allow for a full query with the longest stalls on both
    // sides of every beat and then several times that again.
    localparam int MAX_CYCLES   = 1_200_000;
    localparam int SETTLE_CYCLES = 120;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    time_window_sample_stats u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ring model: same bookkeeping as the block, oldest entry at ring_head.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] ring_samples [DEPTH];
    logic signed [TIME_W-1:0]   ring_stamps  [DEPTH];
    int                         ring_fill;
    int                         ring_head;

    rsp_t stats_expected [$];
    int   error_count;

    // Run tallies for the summary.
    int adds_sent;
    int queries_sent;
    int clears_sent;
    int unused_sent;
    int deepest_fill;

    // Idle controls, set per test: percent chance that a beat is followed by
    // a sender gap, and percent chance per cycle that the receiver stalls.
    int tx_gap_pct;
    int rx_stall_pct;
    int rx_stall_left;

    // Time base that the well-formed sequences advance.
    logic signed [TIME_W-1:0] stim_now;

    // Advance the ring model by one request and return the response it owes.
    function automatic rsp_t window_stats_predict(input req_t item);
        rsp_t                       res;
        longint                     threshold;
        longint                     sum;
        int                         first;
        int                         k;
        int                         pos;
        int                         hits;
        logic signed [SAMPLE_W-1:0] v;
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] lo;
        res = '0;
        case (item.req_type)
            REQ_ADD:
            begin
                // A full ring overwrites the oldest entry and moves the head.
                if (ring_fill >= DEPTH)
                begin
                    pos = ring_head;
                    ring_head = (ring_head + 1) % DEPTH;
                end
                else
                begin
                    pos = (ring_head + ring_fill) % DEPTH;
                    ring_fill++;
                end
                ring_samples[pos] = item.sample_value;
                ring_stamps[pos]  = item.timestamp;
            end
            REQ_QUERY:
            begin
                // Exact threshold, no 32-bit wrap.
                threshold = longint'(item.timestamp) - longint'(item.window_age);
                first = ring_fill;
                for (k = 0; k < ring_fill; k++)
                begin
                    if (first == ring_fill &&
                        longint'(ring_stamps[(ring_head + k) % DEPTH]) >= threshold)
                    begin
                        first = k;
                    end
                end
                // Window is the whole suffix from the first hit, even when
                // later stamps run backwards.
                sum = 0;
                hi  = SAMPLE_MIN;
                lo  = SAMPLE_MAX;
                for (k = first; k < ring_fill; k++)
                begin
                    v = ring_samples[(ring_head + k) % DEPTH];
                    sum += v;
                    if (v > hi)
                    begin
                        hi = v;
                    end
                    if (v < lo)
                    begin
                        lo = v;
                    end
                end
                hits = ring_fill - first;
                if (hits != 0)
                begin
                    res.window_average = SAMPLE_W'(sum / longint'(hits));
                end
                res.window_maximum = hi;
                res.window_minimum = lo;
                res.window_count   = CNT_W'(hits);
            end
            REQ_CLEAR:
            begin
                ring_fill = 0;
                ring_head = 0;
            end
            default:
            begin
            end
        endcase
        res.stored_count = CNT_W'(ring_fill);
        return res;
    endfunction

    function automatic req_t make_req(input logic [1:0]                 kind,
                                      input logic signed [SAMPLE_W-1:0] value,
                                      input logic signed [TIME_W-1:0]   stamp,
                                      input logic [AGE_W-1:0]           age);
        req_t item;
        item.req_type     = kind;
        item.sample_value = value;
        item.timestamp    = stamp;
        item.window_age   = age;
        return item;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 9) != 0)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Drop valid for the given idle stretch; scramble the payload to show it is ignored.
    task automatic idle_sender(input int n);
        @(negedge clk);
        req_valid = 1'b0;
        req = make_req(2'($urandom_range(0, 3)), SAMPLE_W'($urandom), $urandom,
                       AGE_W'($urandom));
        repeat (n - 1) @(negedge clk);
    endtask

    // Present one beat, hold it through stalls, and log the expected response
    // at the edge where it is taken. Valid stays high for a back-to-back beat.
    task automatic send_request(input req_t item);
        @(negedge clk);
        req_valid = 1'b1;
        req = item;
        do
            @(posedge clk);
        while (req_stall);
        stats_expected.push_back(window_stats_predict(item));
        case (item.req_type)
            REQ_ADD:   adds_sent++;
            REQ_QUERY: queries_sent++;
            REQ_CLEAR: clears_sent++;
            default:   unused_sent++;
        endcase
        if (ring_fill > deepest_fill)
        begin
            deepest_fill = ring_fill;
        end
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            idle_sender(idle_length());
        end
    endtask

    // Hold off the sender until every outstanding response has come back.
    task automatic wait_drained();
        @(negedge clk);
        req_valid = 1'b0;
        wait (stats_expected.size() == 0);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall bursts and the scoreboard check.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            rsp_stall = 1'b1;
            rx_stall_left--;
        end
        else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
        begin
            rsp_stall = 1'b1;
            rx_stall_left = idle_length() - 1;
        end
        else
        begin
            rsp_stall = 1'b0;
        end
    end

    task automatic report_mismatch(input string field, input longint want,
                                   input longint got);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_response
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (stats_expected.size() == 0)
            begin
                $display("%0t: response with none expected: avg %0d max %0d min %0d cnt %0d held %0d",
                         $time, rsp.window_average, rsp.window_maximum,
                         rsp.window_minimum, rsp.window_count, rsp.stored_count);
                error_count++;
            end
            else
            begin
                want = stats_expected.pop_front();
                if (rsp.window_average !== want.window_average)
                begin
                    report_mismatch("window_average", want.window_average,
                                    rsp.window_average);
                end
                if (rsp.window_maximum !== want.window_maximum)
                begin
                    report_mismatch("window_maximum", want.window_maximum,
                                    rsp.window_maximum);
                end
                if (rsp.window_minimum !== want.window_minimum)
                begin
                    report_mismatch("window_minimum", want.window_minimum,
                                    rsp.window_minimum);
                end
                if (rsp.window_count !== want.window_count)
                begin
                    report_mismatch("window_count", want.window_count, rsp.window_count);
                end
                if (rsp.stored_count !== want.stored_count)
                begin
                    report_mismatch("stored_count", want.stored_count, rsp.stored_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Queries, clear and the unused code against an empty ring.
    task automatic test_empty_ring();
        send_request(make_req(REQ_QUERY, 16'sd0, 32'sd0, '0));
        send_request(make_req(REQ_QUERY, 16'sd5, TIME_MIN, AGE_MAX));
        send_request(make_req(REQ_CLEAR, 16'sd0, 32'sd0, '0));
        send_request(make_req(REQ_UNUSED, SAMPLE_MAX, TIME_MAX, AGE_MAX));
    endtask

    // Extreme samples and stamps, out-of-order stamps, a threshold below the
    // 32-bit range, empty windows on a held ring, and truncation toward zero.
    task automatic test_extremes_and_truncation();
        send_request(make_req(REQ_ADD, SAMPLE_MAX, TIME_MIN, AGE_MAX));
        send_request(make_req(REQ_ADD, SAMPLE_MIN, TIME_MAX, '0));
        send_request(make_req(REQ_ADD, -16'sd3, 32'sd100, '0));
        send_request(make_req(REQ_ADD, -16'sd2, 32'sd50, '0));
        send_request(make_req(REQ_QUERY, 16'sd0, 32'sd100, '0));
        send_request(make_req(REQ_QUERY, 16'sd0, TIME_MIN, AGE_MAX));
        send_request(make_req(REQ_QUERY, 16'sd0, TIME_MAX, '0));
        send_request(make_req(REQ_QUERY, 16'sd0, TIME_MAX, AGE_MAX));
        send_request(make_req(REQ_UNUSED, -16'sd1, -32'sd1, AGE_MAX));
        send_request(make_req(REQ_CLEAR, -16'sd1, -32'sd1, AGE_MAX));
        send_request(make_req(REQ_QUERY, 16'sd0, 32'sd0, AGE_MAX));
        // -5 / 2 must give -2, not -3.
        send_request(make_req(REQ_ADD, -16'sd3, 32'sd10, '0));
        send_request(make_req(REQ_ADD, -16'sd2, 32'sd20, '0));
        send_request(make_req(REQ_QUERY, 16'sd0, 32'sd20, 31'd100));
        send_request(make_req(REQ_QUERY, 16'sd0, 32'sd20, 31'd5));
        // Stamps all older than the threshold: empty window, ring still held.
        send_request(make_req(REQ_QUERY, 16'sd0, 32'sd1000, '0));
        send_request(make_req(REQ_ADD, 16'sd0, -32'sd1, '0));
        send_request(make_req(REQ_ADD, 16'sd7, 32'sd20, '0));
        send_request(make_req(REQ_QUERY, 16'sd0, 32'sd20, '0));
        send_request(make_req(REQ_QUERY, 16'sd0, -32'sd1, '0));
        send_request(make_req(REQ_CLEAR, 16'sd0, 32'sd0, '0));
    endtask

    // Overfill the ring so the oldest entries drop, then query across it.
    task automatic test_ring_overflow(input int rounds);
        int r;
        int k;
        int n;
        for (r = 0; r < rounds; r++)
        begin
            send_request(make_req(REQ_CLEAR, 16'sd0, 32'sd0, '0));
            stim_now = $urandom;
            n = DEPTH + $urandom_range(2, 20);
            for (k = 0; k < n; k++)
            begin
                stim_now = stim_now + TIME_W'($urandom_range(0, 30));
                send_request(make_req(REQ_ADD, SAMPLE_W'($urandom), stim_now,
                                      AGE_W'($urandom)));
            end
            send_request(make_req(REQ_QUERY, 16'sd0, stim_now, '0));
            send_request(make_req(REQ_QUERY, 16'sd0, stim_now, AGE_W'($urandom_range(0, 900))));
            send_request(make_req(REQ_QUERY, 16'sd0, stim_now, AGE_MAX));
            send_request(make_req(REQ_QUERY, 16'sd0, stim_now + 32'sd100000, '0));
        end
    endtask

    function automatic logic [AGE_W-1:0] pick_age();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            return '0;
        end
        if (roll < 15)
        begin
            return AGE_MAX;
        end
        if (roll < 25)
        begin
            return AGE_W'($urandom);
        end
        return AGE_W'($urandom_range(0, 2500));
    endfunction

    // Mostly well-formed traffic: bursts of adds on an advancing clock, then
    // queries over spans of the held history; a few clears, the odd restart of
    // the time base, and fully random noise beats.
    task automatic test_random_windows(input int n_items);
        int sent;
        int roll;
        int k;
        int burst;
        logic signed [TIME_W-1:0] stamp;
        sent = 0;
        stim_now = $urandom;
        while (sent < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                burst = $urandom_range(1, 12);
                for (k = 0; k < burst; k++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 85)
                    begin
                        stim_now = stim_now + TIME_W'($urandom_range(0, 50));
                        stamp = stim_now;
                    end
                    else if (roll < 95)
                    begin
                        stamp = stim_now - TIME_W'($urandom_range(0, 200));
                    end
                    else
                    begin
                        stamp = stim_now;
                    end
                    send_request(make_req(REQ_ADD, SAMPLE_W'($urandom), stamp,
                                          AGE_W'($urandom)));
                end
                sent += burst;
            end
            if (roll < 85)
            begin
                burst = $urandom_range(1, 3);
                for (k = 0; k < burst; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        stamp = stim_now - TIME_W'($urandom_range(0, 100));
                    end
                    else
                    begin
                        stamp = stim_now + TIME_W'($urandom_range(0, 40));
                    end
                    send_request(make_req(REQ_QUERY, SAMPLE_W'($urandom), stamp,
                                          pick_age()));
                end
                sent += burst;
            end
            else if (roll < 88)
            begin
                send_request(make_req(REQ_CLEAR, SAMPLE_W'($urandom), $urandom,
                                      AGE_W'($urandom)));
                if ($urandom_range(0, 1) == 0)
                begin
                    stim_now = $urandom;
                end
                sent++;
            end
            else if (roll < 90)
            begin
                wait_drained();
            end
            else
            begin
                send_request(make_req(2'($urandom_range(0, 3)), SAMPLE_W'($urandom),
                                      $urandom, AGE_W'($urandom)));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        error_count   = 0;
        adds_sent     = 0;
        queries_sent  = 0;
        clears_sent   = 0;
        unused_sent   = 0;
        deepest_fill  = 0;
        ring_fill     = 0;
        ring_head     = 0;
        tx_gap_pct    = 0;
        rx_stall_pct  = 0;
        rx_stall_left = 0;
        stim_now      = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_empty_ring();
        tx_gap_pct   = 30;
        rx_stall_pct = 20;
        test_extremes_and_truncation();
        test_ring_overflow(2);
        // Let the block fall fully idle before the free-running traffic.
        wait_drained();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        test_random_windows(450);
        tx_gap_pct   = 25;
        rx_stall_pct = 15;
        test_random_windows(650);
        tx_gap_pct   = 5;
        rx_stall_pct = 50;
        test_random_windows(120);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d adds, %0d queries, %0d clears, %0d unused-code beats;",
                 adds_sent, queries_sent, clears_sent, unused_sent);
        $display("ring filled to %0d entries, with overwrite, idle gaps and stalls on both sides.",
                 deepest_fill);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop if the traffic hangs.
    initial
    begin
        repeat (MAX_CYCLES) @(posedge clk);
        $display("Timeout after %0d cycles with %0d responses outstanding",
                 MAX_CYCLES, stats_expected.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

[time_window_sample_stats.f]
design/twss_pkg.sv
design/twss_ram.sv
design/twss_div.sv
design/time_window_sample_stats.sv
dv/time_window_sample_stats_tb.sv
